/* sv/utf8_stream_decoder_assert.svh */
// Assertion macros shared by the checker of the stream decoder.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define U8SD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u8sd assertion failed: same-cycle property");

// Consequent must hold in the cycle after the antecedent.
`define U8SD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u8sd assertion failed: next-cycle property");

`endif

/* sv/u8sd_pkg.sv */
`timescale 1ns / 1ps

package u8sd_pkg;

  // Bit patterns of UTF-8 lead and continuation bytes.
  localparam logic [7:0] MASK_ASCII = 8'h80;
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] TAG_CONT   = 8'h80;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] TAG_LEAD2  = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] TAG_LEAD3  = 8'hE0;
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] TAG_LEAD4  = 8'hF0;

  localparam int CP_W    = 21;
  localparam int TAKE_W  = 3;
  localparam int PEND_N  = 3;
  localparam int WIN_N   = PEND_N + 1;

  // Decode window: pending bytes followed by the new byte, entry 0 is the lead.
  typedef logic [WIN_N-1:0][7:0]  win_t;
  typedef logic [PEND_N-1:0][7:0] pend_t;

  // Outcome of one decode attempt at the head of the window.
  typedef struct packed {
    logic              emit;
    logic [CP_W-1:0]   val;
    logic [TAKE_W-1:0] take;
  } decision_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic step;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic emit;
    logic last;
    logic out_free;
  } status_t;

  function automatic logic is_cont(input logic [7:0] b);
    return (b & MASK_CONT) == TAG_CONT;
  endfunction

  // Decide what the sequence at the head of the window yields.
  function automatic decision_t decode(input win_t w, input logic [2:0] avail,
                                       input logic eos);
    decision_t   d;
    logic [7:0]  lead;
    logic [2:0]  len;
    logic        bad;
    lead = w[0];
    d    = '0;
    if ((lead & MASK_ASCII) == 8'h00) begin
      len = 3'd1;
    end else if ((lead & MASK_LEAD2) == TAG_LEAD2) begin
      len = 3'd2;
    end else if ((lead & MASK_LEAD3) == TAG_LEAD3) begin
      len = 3'd3;
    end else if ((lead & MASK_LEAD4) == TAG_LEAD4) begin
      len = 3'd4;
    end else begin
      len = 3'd1;
    end
    // A byte that has arrived inside the sequence but is no continuation.
    bad = ((len >= 3'd2) && (avail >= 3'd2) && !is_cont(w[1])) ||
          ((len >= 3'd3) && (avail >= 3'd3) && !is_cont(w[2])) ||
          ((len == 3'd4) && (avail == 3'd4) && !is_cont(w[3]));
    if (avail == 3'd0) begin
      d.emit = 1'b0;
    end else if (len == 3'd1 || bad) begin
      d.emit = 1'b1;
      d.val  = {13'd0, lead};
      d.take = 3'd1;
    end else if (avail < len) begin
      // Truncated sequence: wait for more bytes unless the stream ends here.
      d.emit = eos;
      d.val  = {13'd0, lead};
      d.take = 3'd1;
    end else begin
      d.emit = 1'b1;
      d.take = len;
      case (len)
        3'd2:    d.val = {10'd0, lead[4:0], w[1][5:0]};
        3'd3:    d.val = {5'd0, lead[3:0], w[1][5:0], w[2][5:0]};
        default: d.val = {lead[2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
      endcase
    end
    return d;
  endfunction

  // Drop the bytes that a result has covered from the front of the window.
  function automatic win_t shift_win(input win_t w, input logic [2:0] take);
    win_t r;
    case (take)
      3'd1:    r = {8'h00, w[3:1]};
      3'd2:    r = {16'h0000, w[3:2]};
      3'd3:    r = {24'h000000, w[3]};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* sv/u8sd_in_if.sv */
`timescale 1ns / 1ps

// Byte channel into the decoder.
interface u8sd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

/* sv/u8sd_out_if.sv */
`timescale 1ns / 1ps

// Code point channel out of the decoder.
interface u8sd_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [2:0]  bytes_consumed;
  logic        last_of_run;

  modport source (output valid, output code_point, output bytes_consumed,
                  output last_of_run, input ready);
  modport sink   (input valid, input code_point, input bytes_consumed,
                  input last_of_run, output ready);
endinterface

/* sv/u8sd_ctrl.sv */
`timescale 1ns / 1ps

module u8sd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  u8sd_pkg::status_t status,
  output logic              in_ready,
  output u8sd_pkg::cmd_t    cmd
);
  import u8sd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   act;

  // A new item is taken only in idle and only when the output register can load.
  assign in_ready   = (state == ST_IDLE) && status.out_free;
  assign cmd.accept = in_ready && in_valid;
  assign cmd.step   = (state == ST_RUN) && status.out_free;
  assign act        = cmd.accept || cmd.step;

  // Stay in run while the item still owes results after the one just loaded.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (act && status.emit && !status.last) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (act && (!status.emit || status.last)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

/* sv/u8sd_datapath.sv */
`timescale 1ns / 1ps

module u8sd_datapath (
  input  logic               clk,
  input  logic               rst,
  input  u8sd_pkg::cmd_t     cmd,
  output u8sd_pkg::status_t  status,
  input  logic [7:0]         data_byte,
  input  logic               end_of_stream,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [20:0]        code_point,
  output logic [2:0]         bytes_consumed,
  output logic               last_of_run
);
  import u8sd_pkg::*;

  pend_t      pend;
  logic [1:0] cnt;
  logic       eos;

  win_t       win;
  win_t       rest;
  logic [2:0] avail;
  logic [2:0] rem_avail;
  logic       eos_w;
  decision_t  d_head;
  decision_t  d_next;
  logic       last;
  logic       act;
  logic       load;

  // Build the window: pending bytes, plus the incoming byte on an accept.
  always_comb begin
    win = {8'h00, pend};
    if (cmd.accept) begin
      win[cnt] = data_byte;
      avail    = {1'b0, cnt} + 3'd1;
      eos_w    = end_of_stream;
    end else begin
      avail    = {1'b0, cnt};
      eos_w    = eos;
    end
  end

  // Decode the head, then look one sequence ahead to mark the last result.
  always_comb begin
    d_head    = decode(win, avail, eos_w);
    rest      = shift_win(win, d_head.take);
    rem_avail = avail - d_head.take;
    d_next    = decode(rest, rem_avail, eos_w);
    last      = (rem_avail == 3'd0) || !d_next.emit;
  end

  assign act  = cmd.accept || cmd.step;
  assign load = act && d_head.emit;

  assign status.emit     = d_head.emit;
  assign status.last     = last;
  assign status.out_free = !out_valid || out_ready;

  // Pending bytes: keep what the decode left over.
  always_ff @(posedge clk) begin
    if (act) begin
      if (d_head.emit) begin
        pend <= rest[PEND_N-1:0];
      end else begin
        pend <= win[PEND_N-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      eos <= 1'b0;
    end else if (act) begin
      eos <= eos_w;
      if (d_head.emit) begin
        cnt <= rem_avail[1:0];
      end else begin
        cnt <= avail[1:0];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_point     <= d_head.val;
      bytes_consumed <= d_head.take;
      last_of_run    <= last;
    end
  end
endmodule

/* sv/utf8_stream_decoder.sv */
`timescale 1ns / 1ps

// Channel  Role   Payload
// in_ch    sink   data_byte[7:0], end_of_stream
// out_ch   source code_point[20:0], bytes_consumed[2:0], last_of_run
//
// Each result that a byte causes beyond the first holds off the next byte, since
// one sequence is decoded per cycle, while the output is not stalled, into the
// single output register.
// rst is synchronous and clears the pending count and the output valid.
// A stalled output holds off new input bytes until its item is taken.
module utf8_stream_decoder (
  input logic     clk,
  input logic     rst,
  u8sd_in_if.sink    in_ch,
  u8sd_out_if.source out_ch
);
  import u8sd_pkg::*;

  cmd_t    cmd;
  status_t status;

  u8sd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .status   (status),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  u8sd_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .data_byte      (in_ch.data_byte),
    .end_of_stream  (in_ch.end_of_stream),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .code_point     (out_ch.code_point),
    .bytes_consumed (out_ch.bytes_consumed),
    .last_of_run    (out_ch.last_of_run)
  );
endmodule

/* sv/u8sd_checker.sv */
`timescale 1ns / 1ps
`include "utf8_stream_decoder_assert.svh"

module u8sd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] code_point,
  input logic [2:0]  bytes_consumed,
  input logic        last_of_run
);
  // A stalled result keeps its value.
  `U8SD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(code_point) && $stable(bytes_consumed) && $stable(last_of_run))

  // Coming out of reset nothing is offered.
  `U8SD_ASSERT_NOW(a_reset_quiet, $past(rst), !out_valid)

  // A one-byte result is an ASCII code or a raw byte, never wider.
  `U8SD_ASSERT_NOW(a_single_byte, out_valid && bytes_consumed == 3'd1, code_point[20:8] == 13'd0)

  // While an item still owes results, no new byte is taken.
  `U8SD_ASSERT_NOW(a_run_blocks_input, out_valid && !last_of_run, !in_ready)
endmodule

bind utf8_stream_decoder u8sd_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .code_point     (out_ch.code_point),
  .bytes_consumed (out_ch.bytes_consumed),
  .last_of_run    (out_ch.last_of_run)
);

/* tb/sv/tb_utf8_stream_decoder.sv */
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;
  import u8sd_pkg::*;

  // No item may be stuck longer than this many cycles.
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLDOFF_LEN  = 300;
  localparam int TAIL_CYCLES  = 16;
  localparam int MAX_PRINTED  = 20;

  // One decoded code point as it should leave the block.
  typedef struct packed {
    logic [20:0] cp;
    logic [2:0]  len;
    logic        last;
  } point_t;

  logic clk;
  logic rst;

  u8sd_in_if  in_ch ();
  u8sd_out_if out_ch ();

  utf8_stream_decoder u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: bytes of an unfinished sequence.
  logic [7:0]  held_bytes [PEND_N];
  int unsigned held_count;
  point_t      expected_points [$];

  int send_idle_pct;
  int stall_pct;
  int holdoff_cycles;
  int bytes_sent;
  int bytes_taken;
  int points_checked;
  int raw_fallbacks;
  int multi_point_bytes;
  int errors;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
  endtask

  // Work out every code point that one incoming byte settles, in stream order.
  task automatic predict_code_points(input logic [7:0] b, input logic eos);
    logic [7:0]  win [WIN_N];
    point_t      run [WIN_N];
    logic [7:0]  lead;
    logic [20:0] cp;
    logic        bad;
    logic        waiting;
    int          n;
    int          pos;
    int          avail;
    int          len;
    int          seen;
    int          nres;
    int          i;
    n = held_count;
    for (i = 0; i < n; i++) win[i] = held_bytes[i];
    win[n] = b;
    n++;
    pos = 0;
    nres = 0;
    waiting = 1'b0;
    while (pos < n && !waiting) begin
      lead = win[pos];
      avail = n - pos;
      if ((lead & MASK_ASCII) == 8'h00) len = 1;
      else if ((lead & MASK_LEAD2) == TAG_LEAD2) len = 2;
      else if ((lead & MASK_LEAD3) == TAG_LEAD3) len = 3;
      else if ((lead & MASK_LEAD4) == TAG_LEAD4) len = 4;
      else len = 0;
      // Raw lead byte unless a whole, well-formed sequence is present.
      run[nres].cp = {13'd0, lead};
      run[nres].len = 3'd1;
      run[nres].last = 1'b0;
      if (len == 0) begin
        raw_fallbacks++;
      end else if (len > 1) begin
        seen = (avail < len) ? avail : len;
        bad = 1'b0;
        for (i = 1; i < seen; i++) begin
          if ((win[pos + i] & MASK_CONT) != TAG_CONT) bad = 1'b1;
        end
        if (!bad && avail >= len) begin
          cp = {13'd0, lead & (8'h7F >> len)};
          for (i = 1; i < len; i++) cp = {cp[14:0], win[pos + i][5:0]};
          run[nres].cp = cp;
          run[nres].len = len[2:0];
        end else if (!bad && !eos) begin
          waiting = 1'b1;
        end else begin
          raw_fallbacks++;
        end
      end
      if (!waiting) begin
        pos += run[nres].len;
        nres++;
      end
    end
    if (nres > 0) run[nres - 1].last = 1'b1;
    if (nres > 1) multi_point_bytes++;
    for (i = 0; i < nres; i++) expected_points.push_back(run[i]);
    held_count = n - pos;
    for (i = 0; i < held_count; i++) held_bytes[i] = win[pos + i];
  endtask

  // Predict on every accepted byte and check every accepted code point.
  always @(posedge clk) begin : monitor
    point_t want;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_code_points(in_ch.data_byte, in_ch.end_of_stream);
        bytes_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        points_checked++;
        if (expected_points.size() == 0) begin
          report_mismatch($sformatf("code point %06h arrived with none expected",
                                    out_ch.code_point));
        end else begin
          want = expected_points.pop_front();
          if (out_ch.code_point !== want.cp)
            report_mismatch($sformatf("code_point got %06h want %06h",
                                      out_ch.code_point, want.cp));
          if (out_ch.bytes_consumed !== want.len)
            report_mismatch($sformatf("bytes_consumed got %0d want %0d (cp %06h)",
                                      out_ch.bytes_consumed, want.len, want.cp));
          if (out_ch.last_of_run !== want.last)
            report_mismatch($sformatf("last_of_run got %0b want %0b (cp %06h)",
                                      out_ch.last_of_run, want.last, want.cp));
        end
      end
    end
  end

  // Output side: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (holdoff_cycles > 0) begin
      holdoff_cycles = holdoff_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // End the run if no item moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t ns: no item moved for %0d cycles", $time, quiet);
    $display("utf8_stream_decoder test failed");
    $finish;
  end

  // Offer one byte, with random gaps ahead of it, and wait until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.end_of_stream <= eos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Drop valid for one cycle so a phase change cannot repeat the last byte.
  task automatic pause_input();
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] lead_byte(input int len);
    logic [7:0] r;
    r = 8'($urandom_range(255));
    case (len)
      1:       r[7]   = 1'b0;
      2:       r[7:5] = 3'b110;
      3:       r[7:4] = 4'b1110;
      default: r[7:3] = 5'b11110;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cont_byte();
    logic [7:0] r;
    r = 8'($urandom_range(255));
    r[7:6] = 2'b10;
    return r;
  endfunction

  // Mostly well-formed text with random content, plus noise and cut sequences.
  task automatic send_random_text(input int count);
    logic [7:0] seq [WIN_N];
    int first;
    int kind;
    int len;
    int cut;
    int i;
    first = bytes_sent;
    while (bytes_sent - first < count) begin
      kind = $urandom_range(99);
      len = $urandom_range(1, 4);
      seq[0] = lead_byte(len);
      for (i = 1; i < WIN_N; i++) seq[i] = cont_byte();
      if (kind < 15) begin
        send_byte(8'($urandom_range(255)), $urandom_range(99) < 4);
      end else begin
        // A cut sequence leaves its lead for the next byte or the stream end.
        cut = (kind < 28 && len > 1) ? $urandom_range(1, len - 1) : len;
        for (i = 0; i < cut; i++) send_byte(seq[i], $urandom_range(99) < 4);
      end
    end
  endtask

  // Sample values of each length, every failure path and the worst-case flush.
  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct = 0;
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hC2, 1'b0); send_byte(8'hA9, 1'b0);
    send_byte(8'hEF, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    // Largest value a four-byte form can carry.
    send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    // Bytes that can never start a sequence.
    send_byte(8'h80, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hF8, 1'b0);
    // A plain byte where a continuation belongs.
    send_byte(8'hE2, 1'b0); send_byte(8'h41, 1'b0);
    // Stream ends inside a four-byte sequence.
    send_byte(8'hF0, 1'b0); send_byte(8'h9F, 1'b0); send_byte(8'h98, 1'b1);
    // Three held bytes fail at once, giving four code points from one byte.
    send_byte(8'hF0, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0); send_byte(8'h41, 1'b0);
    send_byte(8'h5A, 1'b1);
    pause_input();
  endtask

  task automatic test_random_no_idle();
    send_idle_pct = 0;
    stall_pct = 0;
    send_random_text(80);
    pause_input();
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct = 58;
    stall_pct = 0;
    send_random_text(80);
    pause_input();
  endtask

  task automatic test_random_receiver_stall();
    send_idle_pct = 0;
    stall_pct = 58;
    send_random_text(80);
    pause_input();
  endtask

  task automatic test_random_both_idle();
    send_idle_pct = 7;
    stall_pct = 7;
    send_random_text(80);
    pause_input();
  endtask

  // The output is held off while bytes keep coming, so the input must stall.
  task automatic test_output_holdoff();
    send_idle_pct = 0;
    stall_pct = 0;
    @(posedge clk);
    holdoff_cycles = HOLDOFF_LEN;
    @(negedge clk);
    send_random_text(40);
    pause_input();
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.end_of_stream = 1'b0;
    out_ch.ready = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    holdoff_cycles = 0;
    held_count = 0;
    bytes_sent = 0;
    bytes_taken = 0;
    points_checked = 0;
    raw_fallbacks = 0;
    multi_point_bytes = 0;
    errors = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_output_holdoff();

    // Let every predicted code point come out, then a short quiet tail.
    while (expected_points.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Decoded %0d bytes into %0d code points; %0d raw fallbacks.",
             bytes_taken, points_checked, raw_fallbacks);
    $display("%0d bytes released several code points; %0d mismatches.",
             multi_point_bytes, errors);
    if (errors == 0) begin
      $display("utf8_stream_decoder test passed");
    end else begin
      $display("utf8_stream_decoder test failed");
    end
    $finish;
  end

endmodule
